// ===== design/clsws_pkg.sv =====
// Shared constants, codes and widths for the circular log store.
`default_nettype none

package clsws_pkg;

    // Store geometry
    localparam int LOG_DEPTH = 128;
    localparam int ADDR_W    = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = ADDR_W + 1;          // holds 0..LOG_DEPTH
    localparam int SUM_W     = 16 + ADDR_W;         // LOG_DEPTH * 0xFFFF fits
    localparam int ITER_W    = $clog2(SUM_W);
    localparam int SAT_W     = (CNT_W > 8) ? CNT_W : 8;

    // Field widths
    localparam int ACT_W    = 3;
    localparam int WORD_W   = 16;
    localparam int IDX_W    = 7;
    localparam int ECNT_W   = 8;
    localparam int ENTRY_W  = 2 * WORD_W;
    localparam int CMP_W    = (IDX_W > CNT_W) ? IDX_W + 1 : CNT_W + 1;

    localparam logic [WORD_W-1:0] LEAST_INIT = 16'hFFFF;
    localparam logic [ECNT_W-1:0] COUNT_SAT  = 8'hFF;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd0;
    localparam logic [ACT_W-1:0] ACT_READ  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd2;
    localparam logic [ACT_W-1:0] ACT_COUNT = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STATS = 3'd4;

endpackage

`default_nettype wire

// ===== design/clsws_if.sv =====
// Request and response channel interfaces of the log store.
`default_nettype none

interface clsws_req_if;
    logic                            valid;
    logic                            ready;
    logic [clsws_pkg::ACT_W-1:0]     action;
    logic [clsws_pkg::WORD_W-1:0]    stamp_in;
    logic [clsws_pkg::WORD_W-1:0]    value_in;
    logic [clsws_pkg::IDX_W-1:0]     read_index;

    modport source (output valid, action, stamp_in, value_in, read_index, input ready);
    modport sink   (input valid, action, stamp_in, value_in, read_index, output ready);
endinterface

interface clsws_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [clsws_pkg::WORD_W-1:0]    stamp_out;
    logic [clsws_pkg::WORD_W-1:0]    value_out;
    logic [clsws_pkg::ECNT_W-1:0]    entry_count;
    logic [clsws_pkg::WORD_W-1:0]    least_value;
    logic [clsws_pkg::WORD_W-1:0]    greatest_value;
    logic [clsws_pkg::WORD_W-1:0]    mean_value;
    logic [clsws_pkg::WORD_W-1:0]    span_seconds;
    logic                            log_empty;

    modport source (output valid, stamp_out, value_out, entry_count, least_value,
                    greatest_value, mean_value, span_seconds, log_empty, input ready);
    modport sink   (input valid, stamp_out, value_out, entry_count, least_value,
                    greatest_value, mean_value, span_seconds, log_empty, output ready);
endinterface

`default_nettype wire

// ===== design/clsws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module clsws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                      clk,
    input  wire logic                                      we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                          wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/circular_log_store_with_stats.sv =====
// Top level: circular log store of (timestamp, value) entries with statistics.
//
//   channel | dir | handshake     | payload
//   --------+-----+---------------+------------------------------------------------
//   req     | in  | valid / ready | action, stamp_in, value_in, read_index
//   rsp     | out | valid / ready | stamp_out, value_out, entry_count, least_value,
//           |     |               | greatest_value, mean_value, span_seconds, log_empty
//
// One request at a time; every request gives one response.
// A statistics request on an empty log skips the walk; else the walk covers every stored entry,
// and the divider then produces all SUM_W quotient bits.
// The walk reads the entries one at a time through the single RAM read port,
// and the mean comes from a one-bit-per-cycle restoring divider.
// Reset empties the store at once through per-entry valid bits; clear does the same.
// The response sits in an output register, so a new request is taken while it waits;
// a finished result waits in its last state only if that register is still full.
`default_nettype none

module circular_log_store_with_stats (
    input  wire logic    clk,
    input  wire logic    rst_n,
    clsws_req_if.sink    req,
    clsws_rsp_if.source  rsp
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_READ  = 7'b0000010,   // read data returns
        ST_COUNT = 7'b0000100,   // entry at write position returns
        ST_WALK  = 7'b0001000,   // issue walk address
        ST_ACC   = 7'b0010000,   // fold walk entry into stats
        ST_DIV   = 7'b0100000,   // divider iterations
        ST_DONE  = 7'b1000000    // hand result to output register
    } state_t;

    localparam int AW = clsws_pkg::ADDR_W;
    localparam int CW = clsws_pkg::CNT_W;
    localparam int SW = clsws_pkg::SUM_W;
    localparam int WW = clsws_pkg::WORD_W;

    // Control state
    state_t                          state_reg, state_next;
    logic [AW-1:0]                   pos_reg, pos_next;
    logic [clsws_pkg::LOG_DEPTH-1:0] valid_reg, valid_next;
    logic                            out_valid_reg, out_valid_next;

    // Working registers
    logic [clsws_pkg::ACT_W-1:0]     act_reg, act_next;
    logic                            idx_ok_reg, idx_ok_next;
    logic                            vld_rd_reg;
    logic [CW-1:0]                   cnt_reg, cnt_next;
    logic [AW-1:0]                   walk_reg, walk_next;
    logic [WW-1:0]                   lo_reg, lo_next;
    logic [WW-1:0]                   hi_reg, hi_next;
    logic [WW-1:0]                   first_reg, first_next;
    logic [WW-1:0]                   last_reg, last_next;
    logic [SW-1:0]                   sum_reg, sum_next;     // sum, then quotient
    logic [CW-1:0]                   rem_reg, rem_next;
    logic [clsws_pkg::ITER_W-1:0]    iter_reg, iter_next;
    logic [WW-1:0]                   rd_stamp_reg, rd_stamp_next;
    logic [WW-1:0]                   rd_value_reg, rd_value_next;

    // Output register
    logic [WW-1:0]                   o_stamp_reg, o_stamp_next;
    logic [WW-1:0]                   o_value_reg, o_value_next;
    logic [clsws_pkg::ECNT_W-1:0]    o_count_reg, o_count_next;
    logic [WW-1:0]                   o_least_reg, o_least_next;
    logic [WW-1:0]                   o_great_reg, o_great_next;
    logic [WW-1:0]                   o_mean_reg, o_mean_next;
    logic [WW-1:0]                   o_span_reg, o_span_next;
    logic                            o_empty_reg, o_empty_next;

    // RAM port
    logic                            ram_we;
    logic [AW-1:0]                   ram_raddr;
    logic [clsws_pkg::ENTRY_W-1:0]   ram_rdata;

    logic                            accept;
    logic                            entry_hit;
    logic [WW-1:0]                   ent_stamp;
    logic [WW-1:0]                   ent_value;
    logic [CW:0]                     rem_shift;
    logic [CW:0]                     rem_trial;
    logic [clsws_pkg::ECNT_W-1:0]    count_sat;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign ram_we    = accept && (req.action == clsws_pkg::ACT_WRITE);

    assign ent_stamp = ram_rdata[clsws_pkg::ENTRY_W-1:WW];
    assign ent_value = ram_rdata[WW-1:0];
    // An entry never written since reset or clear reads as zero.
    assign entry_hit = vld_rd_reg && (ram_rdata != '0);

    // Divider step: shift in next dividend bit, subtract divisor if it fits.
    assign rem_shift = {rem_reg, sum_reg[SW-1]};
    assign rem_trial = rem_shift - {1'b0, cnt_reg};

    assign count_sat = (clsws_pkg::SAT_W'(cnt_reg) > clsws_pkg::SAT_W'(clsws_pkg::COUNT_SAT))
                       ? clsws_pkg::COUNT_SAT : clsws_pkg::ECNT_W'(cnt_reg);

    always_comb
    begin
        priority case (1'b1)
            state_reg == ST_IDLE && req.action == clsws_pkg::ACT_READ:
                ram_raddr = AW'(req.read_index);
            state_reg == ST_WALK:
                ram_raddr = walk_reg;
            default:
                ram_raddr = pos_reg;
        endcase
    end

    clsws_ram #(
        .WIDTH (clsws_pkg::ENTRY_W),
        .DEPTH (clsws_pkg::LOG_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata ({req.stamp_in, req.value_in}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        valid_next     = valid_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        act_next       = act_reg;
        idx_ok_next    = idx_ok_reg;
        cnt_next       = cnt_reg;
        walk_next      = walk_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        first_next     = first_reg;
        last_next      = last_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        iter_next      = iter_reg;
        rd_stamp_next  = rd_stamp_reg;
        rd_value_next  = rd_value_reg;
        o_stamp_next   = o_stamp_reg;
        o_value_next   = o_value_reg;
        o_count_next   = o_count_reg;
        o_least_next   = o_least_reg;
        o_great_next   = o_great_reg;
        o_mean_next    = o_mean_reg;
        o_span_next    = o_span_reg;
        o_empty_next   = o_empty_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    act_next    = req.action;
                    idx_ok_next = clsws_pkg::CMP_W'(req.read_index)
                                  < clsws_pkg::CMP_W'(clsws_pkg::LOG_DEPTH);
                    cnt_next    = '0;
                    state_next  = ST_DONE;
                    if (req.action == clsws_pkg::ACT_WRITE)
                    begin
                        valid_next[pos_reg] = 1'b1;
                        pos_next = (32'(pos_reg) == clsws_pkg::LOG_DEPTH - 1)
                                   ? '0 : pos_reg + 1'b1;
                    end
                    else if (req.action == clsws_pkg::ACT_CLEAR)
                    begin
                        valid_next = '0;
                        pos_next   = '0;
                    end
                    else if (req.action == clsws_pkg::ACT_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if (req.action == clsws_pkg::ACT_COUNT
                             || req.action == clsws_pkg::ACT_STATS)
                    begin
                        state_next = ST_COUNT;
                    end
                end
            end

            ST_READ:
            begin
                rd_stamp_next = (idx_ok_reg && vld_rd_reg) ? ent_stamp : '0;
                rd_value_next = (idx_ok_reg && vld_rd_reg) ? ent_value : '0;
                state_next    = ST_DONE;
            end

            ST_COUNT:
            begin
                // Slot at the write position empty: store never wrapped.
                cnt_next   = entry_hit ? CW'(clsws_pkg::LOG_DEPTH) : CW'(pos_reg);
                walk_next  = '0;
                lo_next    = clsws_pkg::LEAST_INIT;
                hi_next    = '0;
                first_next = '0;
                last_next  = '0;
                sum_next   = '0;
                if (act_reg == clsws_pkg::ACT_STATS && entry_hit)
                begin
                    state_next = ST_WALK;
                end
                else if (act_reg == clsws_pkg::ACT_STATS && pos_reg != '0)
                begin
                    state_next = ST_WALK;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_WALK:
            begin
                state_next = ST_ACC;
            end

            ST_ACC:
            begin
                if (entry_hit)
                begin
                    if (walk_reg == '0)
                    begin
                        first_next = ent_stamp;
                    end
                    last_next = ent_stamp;
                    if (ent_value < lo_reg)
                    begin
                        lo_next = ent_value;
                    end
                    if (ent_value > hi_reg)
                    begin
                        hi_next = ent_value;
                    end
                    sum_next = sum_reg + SW'(ent_value);
                end
                if (CW'(walk_reg) + 1'b1 == cnt_reg)
                begin
                    rem_next   = '0;
                    iter_next  = clsws_pkg::ITER_W'(SW - 1);
                    state_next = ST_DIV;
                end
                else
                begin
                    walk_next  = walk_reg + 1'b1;
                    state_next = ST_WALK;
                end
            end

            ST_DIV:
            begin
                if (!rem_trial[CW])
                begin
                    rem_next = rem_trial[CW-1:0];
                    sum_next = {sum_reg[SW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[CW-1:0];
                    sum_next = {sum_reg[SW-2:0], 1'b0};
                end
                iter_next = iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    o_stamp_next   = '0;
                    o_value_next   = '0;
                    o_count_next   = '0;
                    o_least_next   = '0;
                    o_great_next   = '0;
                    o_mean_next    = '0;
                    o_span_next    = '0;
                    o_empty_next   = 1'b0;
                    if (act_reg == clsws_pkg::ACT_READ)
                    begin
                        o_stamp_next = rd_stamp_reg;
                        o_value_next = rd_value_reg;
                    end
                    else if (act_reg == clsws_pkg::ACT_COUNT)
                    begin
                        o_count_next = count_sat;
                        o_empty_next = (cnt_reg == '0);
                    end
                    else if (act_reg == clsws_pkg::ACT_STATS)
                    begin
                        o_count_next = count_sat;
                        o_empty_next = (cnt_reg == '0);
                        o_least_next = lo_reg;
                        o_great_next = hi_reg;
                        o_mean_next  = (cnt_reg == '0) ? '0 : sum_reg[WW-1:0];
                        o_span_next  = last_reg - first_reg;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        vld_rd_reg   <= valid_reg[ram_raddr];
        act_reg      <= act_next;
        idx_ok_reg   <= idx_ok_next;
        cnt_reg      <= cnt_next;
        walk_reg     <= walk_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        sum_reg      <= sum_next;
        rem_reg      <= rem_next;
        iter_reg     <= iter_next;
        rd_stamp_reg <= rd_stamp_next;
        rd_value_reg <= rd_value_next;
        o_stamp_reg  <= o_stamp_next;
        o_value_reg  <= o_value_next;
        o_count_reg  <= o_count_next;
        o_least_reg  <= o_least_next;
        o_great_reg  <= o_great_next;
        o_mean_reg   <= o_mean_next;
        o_span_reg   <= o_span_next;
        o_empty_reg  <= o_empty_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.stamp_out      = o_stamp_reg;
    assign rsp.value_out      = o_value_reg;
    assign rsp.entry_count    = o_count_reg;
    assign rsp.least_value    = o_least_reg;
    assign rsp.greatest_value = o_great_reg;
    assign rsp.mean_value     = o_mean_reg;
    assign rsp.span_seconds   = o_span_reg;
    assign rsp.log_empty      = o_empty_reg;

endmodule

`default_nettype wire
